@@ rtl/sample_record_decoder_top_defines.svh @@
// Assertion macros for the sample record decoder.
// Used by the top level; requires clk and rst in the including scope.
`ifndef SAMPLE_RECORD_DECODER_TOP_DEFINES_SVH
`define SAMPLE_RECORD_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SRD_ASSERT_IMPLIES(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("srd assertion failed");
`define SRD_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("srd assertion failed");
`else
`define SRD_ASSERT_IMPLIES(label, cond, expr)
`define SRD_ASSERT_NEXT(label, cond, expr)
`endif

`endif

@@ rtl/srd_pkg.sv @@
// Shared types, codes and helpers of the sample record decoder.
// No dependencies.
`timescale 1ns / 1ps

package srd_pkg;

  typedef enum logic [7:0] {
    PH_TYPE  = 8'b0000_0001,
    PH_BREF  = 8'b0000_0010,
    PH_BTIME = 8'b0000_0100,
    PH_BVAL  = 8'b0000_1000,
    PH_DREF  = 8'b0001_0000,
    PH_DTIME = 8'b0010_0000,
    PH_EVAL  = 8'b0100_0000,
    PH_DROP  = 8'b1000_0000
  } srd_phase_t;

  typedef logic [1:0] srd_status_t;

  localparam srd_status_t ST_OK         = 2'd0;
  localparam srd_status_t ST_WRONG_TYPE = 2'd1;
  localparam srd_status_t ST_TRUNCATED  = 2'd2;
  localparam srd_status_t ST_OVERFLOW   = 2'd3;

  localparam logic [3:0] WORD_LAST_COUNT   = 4'd8;
  localparam logic [3:0] VARINT_LAST_COUNT = 4'd9;

  typedef struct packed {
    logic        sample_push;
    logic        status_push;
    logic [63:0] series_ref;
    logic [63:0] sample_time;
    logic [63:0] value_bits;
    srd_status_t status;
  } srd_push_t;

  typedef struct packed {
    logic sample_free;
    logic status_free;
  } srd_free_t;

  function automatic logic [63:0] varint_part(input logic [3:0] cnt, input logic [7:0] b);
    logic [63:0] w;
    logic [5:0]  sh;
    w = {57'd0, b[6:0]};
    case (cnt)
      4'd0: sh = 6'd0;
      4'd1: sh = 6'd7;
      4'd2: sh = 6'd14;
      4'd3: sh = 6'd21;
      4'd4: sh = 6'd28;
      4'd5: sh = 6'd35;
      4'd6: sh = 6'd42;
      4'd7: sh = 6'd49;
      4'd8: sh = 6'd56;
      4'd9: sh = 6'd63;
      default: sh = 6'd0;
    endcase
    return w << sh;
  endfunction

endpackage

@@ rtl/srd_parser.sv @@
// Input register, type register and per-byte record parser.
// Depends on srd_pkg; feeds srd_result_buf.
`timescale 1ns / 1ps

module srd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output srd_pkg::srd_push_t push,
  input  srd_pkg::srd_free_t slot_free
);
  import srd_pkg::*;

  logic        in_full;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [7:0]  type_code;

  srd_phase_t  phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [63:0] acc, acc_next;
  logic [63:0] ref_origin, ref_origin_next;
  logic [63:0] time_origin, time_origin_next;
  logic [63:0] pend_ref, pend_ref_next;
  logic [63:0] pend_time, pend_time_next;
  srd_status_t err_code, err_code_next;

  logic [63:0] acc_shift;
  logic [3:0]  cnt_inc;
  logic [63:0] var_acc;
  logic [63:0] delta;
  logic        gen_sample;
  logic [63:0] smp_ref;
  logic [63:0] smp_time;
  srd_status_t end_status;
  logic        fire;

  assign acc_shift = {acc[55:0], in_byte};
  assign cnt_inc   = byte_count + 4'd1;
  assign var_acc   = acc | varint_part(byte_count, in_byte);
  assign delta     = {1'b0, var_acc[63:1]} ^ {64{var_acc[0]}};

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    acc_next         = acc;
    ref_origin_next  = ref_origin;
    time_origin_next = time_origin;
    pend_ref_next    = pend_ref;
    pend_time_next   = pend_time;
    err_code_next    = err_code;
    gen_sample       = 1'b0;
    smp_ref          = pend_ref;
    smp_time         = pend_time;
    case (phase)
      PH_TYPE: begin
        if (in_byte == type_code) begin
          phase_next = PH_BREF;
        end else begin
          err_code_next = ST_WRONG_TYPE;
          phase_next    = PH_DROP;
        end
        byte_count_next = 4'd0;
        acc_next        = 64'd0;
      end
      PH_BREF, PH_BTIME, PH_BVAL, PH_EVAL: begin
        acc_next        = acc_shift;
        byte_count_next = cnt_inc;
        if (cnt_inc >= WORD_LAST_COUNT) begin
          byte_count_next = 4'd0;
          acc_next        = 64'd0;
          if (phase == PH_BREF) begin
            ref_origin_next = acc_shift;
            phase_next      = PH_BTIME;
          end else if (phase == PH_BTIME) begin
            time_origin_next = acc_shift;
            phase_next       = PH_BVAL;
          end else if (phase == PH_BVAL) begin
            gen_sample = 1'b1;
            smp_ref    = ref_origin;
            smp_time   = time_origin;
            phase_next = PH_DREF;
          end else begin
            gen_sample = 1'b1;
            phase_next = PH_DREF;
          end
        end
      end
      PH_DREF, PH_DTIME: begin
        if (byte_count >= VARINT_LAST_COUNT && in_byte > 8'd1) begin
          err_code_next   = ST_OVERFLOW;
          phase_next      = PH_DROP;
          byte_count_next = 4'd0;
          acc_next        = 64'd0;
        end else if (in_byte[7]) begin
          acc_next        = var_acc;
          byte_count_next = cnt_inc;
        end else begin
          if (phase == PH_DREF) begin
            pend_ref_next = ref_origin + delta;
            phase_next    = PH_DTIME;
          end else begin
            pend_time_next = time_origin + delta;
            phase_next     = PH_EVAL;
          end
          byte_count_next = 4'd0;
          acc_next        = 64'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (err_code_next != ST_OK) begin
      end_status = err_code_next;
    end else if ((phase_next == PH_BREF || phase_next == PH_DREF)
                 && byte_count_next == 4'd0) begin
      end_status = ST_OK;
    end else begin
      end_status = ST_TRUNCATED;
    end
  end

  assign fire = in_full
             && (!gen_sample || (slot_free.sample_free && slot_free.status_free))
             && (!in_last || slot_free.status_free);

  assign in_stall = in_full && !fire;

  assign push.sample_push = fire && gen_sample;
  assign push.status_push = fire && in_last;
  assign push.series_ref  = smp_ref;
  assign push.sample_time = smp_time;
  assign push.value_bits  = acc_shift;
  assign push.status      = end_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_code <= 8'd2;
    end else if (cfg_wr_en) begin
      type_code <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && in_last)) begin
      phase       <= PH_TYPE;
      byte_count  <= 4'd0;
      acc         <= 64'd0;
      ref_origin  <= 64'd0;
      time_origin <= 64'd0;
      pend_ref    <= 64'd0;
      pend_time   <= 64'd0;
      err_code    <= ST_OK;
    end else if (fire) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      acc         <= acc_next;
      ref_origin  <= ref_origin_next;
      time_origin <= time_origin_next;
      pend_ref    <= pend_ref_next;
      pend_time   <= pend_time_next;
      err_code    <= err_code_next;
    end
  end

endmodule

@@ rtl/srd_result_buf.sv @@
// Result slots: one for a sample, one for an end-of-record status.
// Depends on srd_pkg; driven by srd_parser.
`timescale 1ns / 1ps

module srd_result_buf (
  input  logic               clk,
  input  logic               rst,
  input  srd_pkg::srd_push_t push,
  output srd_pkg::srd_free_t slot_free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_status,
  output logic [63:0]        series_ref,
  output logic signed [63:0] sample_time,
  output logic [63:0]        value_bits,
  output logic [1:0]         status,
  output logic               end_of_record
);
  import srd_pkg::*;

  logic        s_full;
  logic [63:0] s_ref;
  logic [63:0] s_time;
  logic [63:0] s_val;
  logic        t_full;
  srd_status_t t_code;
  logic        pop;
  logic        pop_s;
  logic        pop_t;

  assign out_valid = s_full || t_full;
  assign pop       = out_valid && !out_stall;
  assign pop_s     = pop && s_full;
  assign pop_t     = pop && !s_full && t_full;

  assign slot_free.sample_free = !s_full || pop_s;
  assign slot_free.status_free = !t_full || pop_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_full <= 1'b0;
      t_full <= 1'b0;
    end else begin
      if (push.sample_push) begin
        s_full <= 1'b1;
      end else if (pop_s) begin
        s_full <= 1'b0;
      end
      if (push.status_push) begin
        t_full <= 1'b1;
      end else if (pop_t) begin
        t_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.sample_push) begin
      s_ref  <= push.series_ref;
      s_time <= push.sample_time;
      s_val  <= push.value_bits;
    end
    if (push.status_push) begin
      t_code <= push.status;
    end
  end

  assign is_status     = !s_full;
  assign end_of_record = !s_full;
  assign series_ref    = s_full ? s_ref : 64'd0;
  assign sample_time   = s_full ? $signed(s_time) : 64'sd0;
  assign value_bits    = s_full ? s_val : 64'd0;
  assign status        = s_full ? ST_OK : t_code;

endmodule

@@ rtl/sample_record_decoder_top.sv @@
// Sample record decoder, top level: parser plus result slots.
// Path: a byte accepted into the input register is parsed from there, and its first result
// is registered in a result slot, from which the output port can take it.
// Throughput: one byte per cycle while the result slots have room; a byte that ends a sample and
// the record yields a sample and a status, both sent through the single result port, sample first.
// Reset (rst, synchronous) clears parse state and slots and sets the type code to 2.
`timescale 1ns / 1ps
`include "sample_record_decoder_top_defines.svh"

module sample_record_decoder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_status,
  output logic [63:0]        series_ref,
  output logic signed [63:0] sample_time,
  output logic [63:0]        value_bits,
  output logic [1:0]         status,
  output logic               end_of_record
);
  import srd_pkg::*;

  srd_push_t push;
  srd_free_t slot_free;

  srd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .push        (push),
    .slot_free   (slot_free)
  );

  srd_result_buf u_result_buf (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_status     (is_status),
    .series_ref    (series_ref),
    .sample_time   (sample_time),
    .value_bits    (value_bits),
    .status        (status),
    .end_of_record (end_of_record)
  );

  `SRD_ASSERT_IMPLIES(a_sample_slot_free, push.sample_push, slot_free.sample_free && slot_free.status_free)
  `SRD_ASSERT_IMPLIES(a_status_slot_free, push.status_push, slot_free.status_free)
  `SRD_ASSERT_IMPLIES(a_sample_clean, out_valid && !is_status, status == ST_OK && !end_of_record)
  `SRD_ASSERT_NEXT(a_status_shows, push.status_push && !push.sample_push, out_valid)

endmodule

@@ tb/sample_record_decoder_checker.sv @@
// Checker for the sample record decoder: watches the config port and both channels,
// decodes each accepted request byte on its own and compares every result in order.
// Depends on srd_pkg for the phase enum, status codes and field length limits.
`timescale 1ns / 1ps

module sample_record_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        is_status,
  input  logic [63:0] series_ref,
  input  logic [63:0] sample_time,
  input  logic [63:0] value_bits,
  input  logic [1:0]  status,
  input  logic        end_of_record,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import srd_pkg::*;

  typedef struct {
    logic        is_st;
    logic [63:0] sref;
    logic [63:0] stime;
    logic [63:0] vbits;
    srd_status_t st;
    logic        eor;
  } decoded_result_t;

  decoded_result_t expected_q[$];

  logic [7:0]  type_code;
  srd_phase_t  phase;
  logic [3:0]  cnt;
  logic [63:0] acc;
  logic [63:0] ref_origin;
  logic [63:0] base_ts;
  logic [63:0] pend_ref;
  logic [63:0] pend_ts;
  srd_status_t err;

  task automatic restart_record();
    phase = PH_TYPE;
    cnt = 4'd0;
    acc = 64'd0;
    ref_origin = 64'd0;
    base_ts = 64'd0;
    pend_ref = 64'd0;
    pend_ts = 64'd0;
    err = ST_OK;
  endtask

  task automatic add_result(input logic is_st, input logic [63:0] r, input logic [63:0] t,
                            input logic [63:0] v, input srd_status_t st);
    decoded_result_t res;
    res.is_st = is_st;
    res.sref = r;
    res.stime = t;
    res.vbits = v;
    res.st = st;
    res.eor = is_st;
    expected_q.insert(expected_q.size(), res);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic [63:0] delta;
    srd_status_t st;
    case (phase)
      PH_TYPE: begin
        if (b == type_code) begin
          phase = PH_BREF;
        end else begin
          err = ST_WRONG_TYPE;
          phase = PH_DROP;
        end
        cnt = 4'd0;
        acc = 64'd0;
      end
      PH_BREF, PH_BTIME, PH_BVAL, PH_EVAL: begin
        acc = {acc[55:0], b};
        cnt = cnt + 4'd1;
        if (cnt >= WORD_LAST_COUNT) begin
          case (phase)
            PH_BREF: begin
              ref_origin = acc;
              phase = PH_BTIME;
            end
            PH_BTIME: begin
              base_ts = acc;
              phase = PH_BVAL;
            end
            PH_BVAL: begin
              add_result(1'b0, ref_origin, base_ts, acc, ST_OK);
              phase = PH_DREF;
            end
            default: begin
              add_result(1'b0, pend_ref, pend_ts, acc, ST_OK);
              phase = PH_DREF;
            end
          endcase
          cnt = 4'd0;
          acc = 64'd0;
        end
      end
      PH_DREF, PH_DTIME: begin
        if (cnt >= VARINT_LAST_COUNT && b > 8'd1) begin
          err = ST_OVERFLOW;
          phase = PH_DROP;
          cnt = 4'd0;
          acc = 64'd0;
        end else begin
          acc = acc | ({57'd0, b[6:0]} << (7 * cnt));
          if (b[7]) begin
            cnt = cnt + 4'd1;
          end else begin
            delta = {1'b0, acc[63:1]} ^ {64{acc[0]}};
            if (phase == PH_DREF) begin
              pend_ref = ref_origin + delta;
              phase = PH_DTIME;
            end else begin
              pend_ts = base_ts + delta;
              phase = PH_EVAL;
            end
            cnt = 4'd0;
            acc = 64'd0;
          end
        end
      end
      default: begin
      end
    endcase
    if (lst) begin
      if (err != ST_OK) begin
        st = err;
      end else if ((phase == PH_BREF || phase == PH_DREF) && cnt == 4'd0) begin
        st = ST_OK;
      end else begin
        st = ST_TRUNCATED;
      end
      add_result(1'b1, 64'd0, 64'd0, 64'd0, st);
      restart_record();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t checker: result %0d: %s", $time, checked, msg);
    fail_count++;
  endtask

  task automatic check_result();
    decoded_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result is_status=%b status=%0d",
                                is_status, status));
    end else begin
      want = expected_q.pop_front();
      if (is_status !== want.is_st)
        report_mismatch($sformatf("is_status got %b want %b", is_status, want.is_st));
      if (series_ref !== want.sref)
        report_mismatch($sformatf("series_ref got %h want %h", series_ref, want.sref));
      if (sample_time !== want.stime)
        report_mismatch($sformatf("sample_time got %h want %h", sample_time, want.stime));
      if (value_bits !== want.vbits)
        report_mismatch($sformatf("value_bits got %h want %h", value_bits, want.vbits));
      if (status !== want.st)
        report_mismatch($sformatf("status got %0d want %0d", status, want.st));
      if (end_of_record !== want.eor)
        report_mismatch($sformatf("end_of_record got %b want %b", end_of_record, want.eor));
      checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_record();
      type_code = 8'd2;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_wr_en) type_code = cfg_wr_data;
      if (in_valid && !in_stall) decode_byte(data_byte, last_byte);
      pending <= expected_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the sample record decoder: clock, reset, record stimulus,
// random idling on both channels, type code changes and the final verdict.
// Depends on sample_record_decoder_top and sample_record_decoder_checker.
`timescale 1ns / 1ps

module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_status;
  logic [63:0] series_ref;
  logic signed [63:0] sample_time;
  logic [63:0] value_bits;
  logic [1:0]  status;
  logic        end_of_record;

  int          fail_count;
  int          pending;
  int          checked;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          bytes_sent = 0;
  int          records_sent = 0;
  logic [7:0]  type_code = 8'd2;
  logic [7:0]  rec_q[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  sample_record_decoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_status     (is_status),
    .series_ref    (series_ref),
    .sample_time   (sample_time),
    .value_bits    (value_bits),
    .status        (status),
    .end_of_record (end_of_record)
  );

  sample_record_decoder_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_status     (is_status),
    .series_ref    (series_ref),
    .sample_time   (sample_time),
    .value_bits    (value_bits),
    .status        (status),
    .end_of_record (end_of_record),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  function automatic logic [63:0] pick_word();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_delta();
    longint sd;
    case ($urandom_range(7))
      0: return {$urandom, $urandom};
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7fff_ffff_ffff_ffff;
      3: return '1;
      4: begin
        sd = int'($urandom);
        return sd;
      end
      default: begin
        sd = $urandom_range(400);
        sd = sd - 200;
        return sd;
      end
    endcase
  endfunction

  function automatic logic [63:0] zigzag(input logic [63:0] d);
    return (d << 1) ^ {64{d[63]}};
  endfunction

  task automatic add_byte(input logic [7:0] b);
    rec_q.insert(rec_q.size(), b);
  endtask

  task automatic put_word(input logic [63:0] w);
    int i;
    for (i = 7; i >= 0; i--) add_byte(w[8*i +: 8]);
  endtask

  // pad some encodings with zero groups up to the full ten bytes
  task automatic put_varint(input logic [63:0] v);
    int          n;
    int          i;
    logic [63:0] r;
    logic [7:0]  grp;
    n = 1;
    r = v >> 7;
    while (r != 0) begin
      n++;
      r = r >> 7;
    end
    if ($urandom_range(3) == 0) n = $urandom_range(10, n);
    for (i = 0; i < n; i++) begin
      grp = {1'b0, 7'((v >> (7 * i)) & 64'h7f)};
      add_byte((i < n - 1) ? (grp | 8'h80) : grp);
    end
  endtask

  task automatic put_random_bytes(input int n);
    int i;
    for (i = 0; i < n; i++) add_byte(8'($urandom));
  endtask

  task automatic build_good(input int entries);
    int i;
    add_byte(type_code);
    put_word(pick_word());
    put_word(pick_word());
    put_word(pick_word());
    for (i = 0; i < entries; i++) begin
      put_varint(zigzag(pick_delta()));
      put_varint(zigzag(pick_delta()));
      put_word(pick_word());
    end
  endtask

  task automatic build_random_record();
    int         kind;
    int         i;
    int         len;
    logic [7:0] first;
    kind = $urandom_range(99);
    if (kind < 60) begin
      build_good($urandom_range(3));
    end else if (kind < 70) begin
      build_good($urandom_range(2));
      len = $urandom_range(rec_q.size() - 1, 2);
      while (rec_q.size() > len) void'(rec_q.pop_back());
    end else if (kind < 78) begin
      first = $urandom;
      if (first == type_code) first = first ^ 8'h01;
      add_byte(first);
      put_random_bytes($urandom_range(6));
    end else if (kind < 86) begin
      build_good($urandom_range(1));
      if ($urandom_range(1)) put_varint(zigzag(pick_delta()));
      for (i = 0; i < 9; i++) add_byte({1'b1, 7'($urandom)});
      add_byte(8'($urandom_range(255, 2)));
      put_random_bytes($urandom_range(4));
    end else if (kind < 94) begin
      add_byte(type_code);
    end else begin
      put_random_bytes($urandom_range(8, 1));
    end
  endtask

  task automatic send_record();
    int i;
    for (i = 0; i < rec_q.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= rec_q[i];
      last_byte <= (i == rec_q.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
    rec_q.delete();
    records_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                            input int n);
    add_byte(b0);
    if (n > 1) add_byte(b1);
    if (n > 2) add_byte(b2);
    send_record();
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_type_code(input logic [7:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    type_code = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] codes[8];
    int         seg;
    codes = '{8'd2, 8'd255, 8'd0, 8'($urandom), 8'd255, 8'd0, 8'($urandom), 8'($urandom)};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_bytes(8'd2, 8'd0, 8'd0, 1);
    send_bytes(8'h00, 8'd0, 8'd0, 1);
    send_bytes(8'hff, 8'h02, 8'h80, 3);
    send_bytes(8'd2, 8'hff, 8'h00, 3);
    send_bytes(8'h03, 8'h02, 8'hff, 3);
    send_bytes(8'd2, 8'h80, 8'h7f, 3);
    drain();

    for (seg = 0; seg < 8; seg++) begin
      if (seg > 0) set_type_code(codes[seg]);
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 62;
        end
        default: begin
          send_idle_pct = 28;
          stall_pct = 28;
        end
      endcase
      while (bytes_sent < 20 + (seg + 1) * 180) begin
        build_random_record();
        send_record();
      end
    end
    drain();
    repeat (8) @(posedge clk);

    $display("tb: %0d bytes in %0d records over 8 type code settings and 4 idling modes,",
             bytes_sent, records_sent);
    $display("tb: %0d results checked, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
